### rtl/core/damped_pendulum_splitting_step_core_defines.svh
// ----------------------------------------------------------------------------
// Damped pendulum step core: assertion macros
// Shorthand for the concurrent checks used inside the core. Each macro expects
// signals named clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef DAMPED_PENDULUM_SPLITTING_STEP_CORE_DEFINES_SVH
`define DAMPED_PENDULUM_SPLITTING_STEP_CORE_DEFINES_SVH

// Same-cycle implication.
`define DPSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define DPSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/dpss_pkg.sv
// ----------------------------------------------------------------------------
// Damped pendulum step core: shared package
// Item types, register indexes and the constants of the angle arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package dpss_pkg;

  typedef struct packed {
    logic               restart;
    logic signed [31:0] ref_position;
    logic signed [31:0] ref_momentum;
    logic signed [31:0] ref_entropy;
  } dpss_in_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] momentum;
    logic signed [31:0] entropy;
    logic signed [31:0] energy_drift;
    logic [62:0]        sq_err_position;
    logic [62:0]        sq_err_momentum;
    logic [62:0]        sq_err_entropy;
    logic [62:0]        sq_err_energy;
  } dpss_out_t;

  typedef enum logic [2:0] {
    CFG_STEP_SIZE       = 3'd0,
    CFG_SPRING_CONSTANT = 3'd1,
    CFG_HALF_STEP_DECAY = 3'd2,
    CFG_HEAT_FRACTION   = 3'd3,
    CFG_THERMAL_ENERGY  = 3'd4,
    CFG_START_POSITION  = 3'd5,
    CFG_START_MOMENTUM  = 3'd6
  } cfg_idx_t;

  // Angles carry 30 fraction bits inside the trigonometry unit.
  localparam int                 ANG_BITS  = 30;
  localparam logic [32:0]        TWO_PI_A  = 33'd6746518852;
  localparam logic signed [34:0] TWO_PI_Z  = 35'sd6746518852;
  localparam logic signed [34:0] PI_Z      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Z = 35'sd1686629713;
  localparam logic signed [33:0] GAIN_X    = 34'sd652032874;

  // Truncated arctangent of 2^-t, 30 fraction bits.
  function automatic logic [31:0] atan_angle(input logic [4:0] t);
    case (t)
      5'd0:  return 32'h3243F6A8;
      5'd1:  return 32'h1DAC6705;
      5'd2:  return 32'h0FADBAFC;
      5'd3:  return 32'h07F56EA6;
      5'd4:  return 32'h03FEAB76;
      5'd5:  return 32'h01FFD55B;
      5'd6:  return 32'h00FFFAAA;
      5'd7:  return 32'h007FFF55;
      5'd8:  return 32'h003FFFEA;
      5'd9:  return 32'h001FFFFD;
      5'd10: return 32'h000FFFFF;
      5'd11: return 32'h0007FFFF;
      5'd12: return 32'h0003FFFF;
      5'd13: return 32'h0001FFFF;
      5'd14: return 32'h0000FFFF;
      5'd15: return 32'h00007FFF;
      5'd16: return 32'h00003FFF;
      5'd17: return 32'h00001FFF;
      5'd18: return 32'h00000FFF;
      5'd19: return 32'h000007FF;
      5'd20: return 32'h000003FF;
      5'd21: return 32'h000001FF;
      5'd22: return 32'h000000FF;
      5'd23: return 32'h0000007F;
      5'd24: return 32'h0000003F;
      5'd25: return 32'h0000001F;
      5'd26: return 32'h0000000F;
      5'd27: return 32'h00000007;
      5'd28: return 32'h00000003;
      5'd29: return 32'h00000001;
      default: return 32'h00000000;
    endcase
  endfunction

endpackage

`default_nettype wire

### rtl/core/dpss_trig.sv
// ----------------------------------------------------------------------------
// Damped pendulum step core: sine and cosine unit
// Reduces an angle modulo two pi by shift and subtract, folds it into the
// right half plane and runs a rotation-mode CORDIC, one step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dpss_trig
  import dpss_pkg::*;
#(
  parameter int FRAC_BITS    = 24,
  parameter int CORDIC_STEPS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] angle,
  output logic                    done,
  output logic signed [31:0]      sine,
  output logic signed [31:0]      cosine
);

  localparam int SH = ANG_BITS - FRAC_BITS;
  localparam int MW = 32 + SH + 2;
  localparam int IW = $clog2(SH + 1);
  localparam int TW = $clog2(CORDIC_STEPS);
  localparam logic signed [33:0] HALF_LSB = 34'sd1 <<< (SH - 1);

  typedef enum logic [2:0] {T_IDLE, T_RED, T_WRAP, T_FOLD, T_ROT, T_DONE} tstate_t;

  tstate_t            state;
  logic [MW-1:0]      mag;
  logic               neg;
  logic [IW-1:0]      idx;
  logic signed [34:0] z;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic               flip;
  logic [TW-1:0]      t;

  logic [31:0]        angle_abs;
  logic [MW-1:0]      red_sub;
  logic signed [34:0] rem_s;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [34:0] at;
  logic signed [33:0] xf;
  logic signed [33:0] yf;
  logic signed [33:0] cos_r;
  logic signed [33:0] sin_r;

  always_comb begin
    angle_abs = angle[31] ? (~angle + 32'd1) : angle;
    red_sub   = MW'(TWO_PI_A) << idx;
    rem_s     = neg ? -$signed({2'b00, mag[32:0]}) : $signed({2'b00, mag[32:0]});
    xs        = x >>> t;
    ys        = y >>> t;
    at        = $signed({3'b000, atan_angle(5'(t))});
    xf        = flip ? -x : x;
    yf        = flip ? -y : y;
    cos_r     = (xf + HALF_LSB) >>> SH;
    sin_r     = (yf + HALF_LSB) >>> SH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        T_IDLE: begin
          if (start) begin
            mag   <= MW'({angle_abs, {SH{1'b0}}});
            neg   <= angle[31];
            idx   <= IW'(SH);
            state <= T_RED;
          end
        end
        T_RED: begin
          if (mag >= red_sub) begin
            mag <= mag - red_sub;
          end
          if (idx == '0) begin
            state <= T_WRAP;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        T_WRAP: begin
          if (rem_s >= PI_Z) begin
            z <= rem_s - TWO_PI_Z;
          end else if (rem_s < -PI_Z) begin
            z <= rem_s + TWO_PI_Z;
          end else begin
            z <= rem_s;
          end
          state <= T_FOLD;
        end
        T_FOLD: begin
          if (z > HALF_PI_Z) begin
            z    <= z - PI_Z;
            flip <= 1'b1;
          end else if (z < -HALF_PI_Z) begin
            z    <= z + PI_Z;
            flip <= 1'b1;
          end else begin
            flip <= 1'b0;
          end
          x     <= GAIN_X;
          y     <= '0;
          t     <= '0;
          state <= T_ROT;
        end
        T_ROT: begin
          if (!z[34]) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - at;
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + at;
          end
          if (t == TW'(CORDIC_STEPS - 1)) begin
            state <= T_DONE;
          end else begin
            t <= t + 1'b1;
          end
        end
        T_DONE: begin
          cosine <= cos_r[31:0];
          sine   <= sin_r[31:0];
          done   <= 1'b1;
          state  <= T_IDLE;
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/damped_pendulum_splitting_step_core.sv
// ----------------------------------------------------------------------------
// Damped pendulum step core
// One damped, force-kicked splitting step of a pendulum per input item, with
// a report of the state, its energy drift and squared reference errors.
// ----------------------------------------------------------------------------
// Usage. Items arrive on in_valid/in_ready/in_item and one result item per
// input item leaves on out_valid/out_ready/out_item. Each input item first
// reports the state as it stands (after a restart, if the item asks for one),
// then advances the state by one time step. Registers are to be written
// through cfg_write/cfg_index/cfg_data only while the core is idle; the core
// does not enforce this. They never alter the stored state, which picks up
// new start values only on reset or restart.
// Datapath. All products run through one 33 by 33 bit multiplier and all
// angles through one sine/cosine unit. A step costs two angle evaluations and
// seventeen products; a restart adds a load of the start state, one more angle
// and three products.
// Reset. After rst the core loads the start state and evaluates its force and
// energy before in_ready rises.
// Stalls. The result sits in an output register; the core finishes the step
// behind it, takes the next item, and waits only before starting the next
// report until the previous result item has been taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "damped_pendulum_splitting_step_core_defines.svh"

module damped_pendulum_splitting_step_core
  import dpss_pkg::*;
#(
  parameter int FRAC_BITS    = 24,
  parameter int CORDIC_STEPS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire dpss_in_t    in_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output dpss_out_t        out_item,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam logic signed [65:0] HALF0 = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [65:0] HALF1 = 66'sd1 <<< FRAC_BITS;

  typedef enum logic [2:0] {
    S_LOAD, S_TRIG_GO, S_TRIG_WAIT, S_OPER, S_MUL, S_ACC, S_WAIT_OUT, S_IDLE
  } state_t;

  // One entry for each product of the step, in the order they are taken.
  typedef enum logic [4:0] {
    OP_I_FORCE, OP_I_KIN, OP_I_PE,
    OP_KIN, OP_PE, OP_TE, OP_SQP, OP_SQM, OP_SQE, OP_SQD,
    OP_D1K, OP_D1M, OP_D1E, OP_K1, OP_DRIFT,
    OP_FORCE, OP_K2, OP_D2K, OP_D2M, OP_D2E
  } op_t;

  // Configuration registers.
  logic [28:0]        step_size;
  logic [28:0]        spring_constant;
  logic [24:0]        half_step_decay;
  logic [24:0]        heat_fraction;
  logic [28:0]        thermal_energy;
  logic signed [31:0] start_position;
  logic signed [31:0] start_momentum;

  // Sequencer and datapath.
  state_t             state;
  op_t                op;
  op_t                ret;
  logic               stepping;
  dpss_in_t           item_r;
  logic signed [31:0] pos;
  logic signed [31:0] mom;
  logic signed [31:0] ent;
  logic signed [31:0] force_r;
  logic signed [31:0] e0;
  logic signed [31:0] tmp;
  logic signed [65:0] acc;
  logic signed [32:0] a_r;
  logic signed [32:0] b_r;
  logic signed [65:0] prod;

  logic signed [32:0] opa;
  logic signed [32:0] opb;
  logic signed [65:0] rnd0;
  logic signed [65:0] rnd1;
  logic [62:0]        sq_sat;

  logic               trig_start;
  logic               trig_done;
  logic signed [31:0] sine;
  logic signed [31:0] cosine;

  function automatic logic signed [32:0] ext33(input logic [31:0] v);
    return $signed({v[31], v});
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  assign in_ready   = (state == S_IDLE);
  assign trig_start = (state == S_TRIG_GO);

  dpss_trig #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_trig (
    .clk    (clk),
    .rst    (rst),
    .start  (trig_start),
    .angle  (pos),
    .done   (trig_done),
    .sine   (sine),
    .cosine (cosine)
  );

  // Scaled-back products: rounding half up at FRAC_BITS, and at FRAC_BITS+1
  // where the product is also halved.
  always_comb begin
    rnd0   = (prod + HALF0) >>> FRAC_BITS;
    rnd1   = (prod + HALF1) >>> (FRAC_BITS + 1);
    sq_sat = (prod[65:63] != 3'b000) ? {63{1'b1}} : prod[62:0];
  end

  // Multiplier operand selection.
  always_comb begin
    opa = '0;
    opb = '0;
    case (op)
      OP_I_FORCE, OP_FORCE, OP_I_PE, OP_PE: begin
        opa = $signed({4'b0000, spring_constant});
        opb = (op == OP_I_PE || op == OP_PE) ? ext33(cosine) : ext33(sine);
      end
      OP_I_KIN, OP_KIN, OP_D1K, OP_D2K: begin
        opa = ext33(mom);
        opb = ext33(mom);
      end
      OP_TE: begin
        opa = $signed({4'b0000, thermal_energy});
        opb = ext33(ent);
      end
      OP_SQP: begin
        opa = ext33(pos) - ext33(item_r.ref_position);
        opb = opa;
      end
      OP_SQM: begin
        opa = ext33(mom) - ext33(item_r.ref_momentum);
        opb = opa;
      end
      OP_SQE: begin
        opa = ext33(ent) - ext33(item_r.ref_entropy);
        opb = opa;
      end
      OP_SQD: begin
        opa = ext33(out_item.energy_drift);
        opb = opa;
      end
      OP_D1M, OP_D2M: begin
        opa = $signed({8'h00, half_step_decay});
        opb = ext33(mom);
      end
      OP_D1E, OP_D2E: begin
        opa = $signed({8'h00, heat_fraction});
        opb = ext33(tmp);
      end
      OP_K1, OP_K2: begin
        opa = $signed({4'b0000, step_size});
        opb = ext33(force_r);
      end
      OP_DRIFT: begin
        opa = $signed({4'b0000, step_size});
        opb = ext33(mom);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // Configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size       <= 29'd1677722;
      spring_constant <= 29'd16777216;
      half_step_decay <= 25'd16777216;
      heat_fraction   <= 25'd0;
      thermal_energy  <= 29'd16777216;
      start_position  <= 32'sd33554432;
      start_momentum  <= 32'sd0;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STEP_SIZE:       step_size       <= cfg_data[28:0];
        CFG_SPRING_CONSTANT: spring_constant <= cfg_data[28:0];
        CFG_HALF_STEP_DECAY: half_step_decay <= cfg_data[24:0];
        CFG_HEAT_FRACTION:   heat_fraction   <= cfg_data[24:0];
        CFG_THERMAL_ENERGY:  thermal_energy  <= cfg_data[28:0];
        CFG_START_POSITION:  start_position  <= cfg_data;
        CFG_START_MOMENTUM:  start_momentum  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer. Operands in S_OPER, the product in S_MUL, its use in S_ACC.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      op        <= OP_I_FORCE;
      ret       <= OP_I_FORCE;
      stepping  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          pos   <= start_position;
          mom   <= start_momentum;
          ent   <= '0;
          ret   <= OP_I_FORCE;
          state <= S_TRIG_GO;
        end
        S_TRIG_GO: state <= S_TRIG_WAIT;
        S_TRIG_WAIT: begin
          if (trig_done) begin
            op    <= ret;
            state <= S_OPER;
          end
        end
        S_OPER: begin
          a_r   <= opa;
          b_r   <= opb;
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= a_r * b_r;
          state <= S_ACC;
        end
        S_ACC: begin
          state <= S_OPER;
          unique case (op)
            OP_I_FORCE: begin
              force_r <= sat32(-rnd0);
              op      <= OP_I_KIN;
            end
            OP_I_KIN: begin
              acc <= rnd1;
              op  <= OP_I_PE;
            end
            OP_I_PE: begin
              e0    <= sat32(acc - rnd0);
              state <= stepping ? S_WAIT_OUT : S_IDLE;
            end
            OP_KIN: begin
              acc <= rnd1;
              op  <= OP_PE;
            end
            OP_PE: begin
              acc <= acc - rnd0;
              op  <= OP_TE;
            end
            OP_TE: begin
              out_item.energy_drift <= sat32(acc + rnd0 - e0);
              op                    <= OP_SQP;
            end
            OP_SQP: begin
              out_item.sq_err_position <= sq_sat;
              op                       <= OP_SQM;
            end
            OP_SQM: begin
              out_item.sq_err_momentum <= sq_sat;
              op                       <= OP_SQE;
            end
            OP_SQE: begin
              out_item.sq_err_entropy <= sq_sat;
              op                      <= OP_SQD;
            end
            OP_SQD: begin
              out_item.sq_err_energy <= sq_sat;
              out_valid              <= 1'b1;
              op                     <= OP_D1K;
            end
            OP_D1K: begin
              tmp <= sat32(rnd1);
              op  <= OP_D1M;
            end
            OP_D1M: begin
              mom <= sat32(rnd0);
              op  <= OP_D1E;
            end
            OP_D1E: begin
              ent <= sat32(ent + rnd0);
              op  <= OP_K1;
            end
            OP_K1: begin
              mom <= sat32(mom + rnd1);
              op  <= OP_DRIFT;
            end
            OP_DRIFT: begin
              pos   <= sat32(pos + rnd0);
              ret   <= OP_FORCE;
              state <= S_TRIG_GO;
            end
            OP_FORCE: begin
              force_r <= sat32(-rnd0);
              op      <= OP_K2;
            end
            OP_K2: begin
              mom <= sat32(mom + rnd1);
              op  <= OP_D2K;
            end
            OP_D2K: begin
              tmp <= sat32(rnd1);
              op  <= OP_D2M;
            end
            OP_D2M: begin
              mom <= sat32(rnd0);
              op  <= OP_D2E;
            end
            OP_D2E: begin
              ent   <= sat32(ent + rnd0);
              state <= S_IDLE;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_WAIT_OUT: begin
          // The report fields are filled in place, so the previous result
          // must have left the output register first.
          if (!out_valid) begin
            out_item.position <= pos;
            out_item.momentum <= mom;
            out_item.entropy  <= ent;
            ret               <= OP_KIN;
            state             <= S_TRIG_GO;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item_r   <= in_item;
            stepping <= 1'b1;
            state    <= in_item.restart ? S_LOAD : S_WAIT_OUT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `DPSS_ASSERT_IMP(a_trig_done_waited, trig_done, state == S_TRIG_WAIT, "angle result arrived unexpectedly")
  `DPSS_ASSERT_NEXT(a_one_item_at_once, in_valid && in_ready, !in_ready, "item taken while busy")
  `DPSS_ASSERT_NEXT(a_result_shown, state == S_ACC && op == OP_SQD, out_valid, "result not presented")

endmodule

`default_nettype wire

### test/damped_pendulum_splitting_step_core_tb.sv
// ----------------------------------------------------------------------------
// Damped pendulum step core: self-checking testbench
// Drives step items through the core under bursty input and a stalling
// receiver, predicts every result item in fixed point or uses a typed-in one,
// compares each field, across several register settings including extremes.
// ----------------------------------------------------------------------------
`default_nettype none

module damped_pendulum_splitting_step_core_tb;
  import dpss_pkg::*;

  // Register index beyond the list; the core must ignore writes to it.
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  localparam int FB = 24;
  localparam int CSTEPS = 24;
  localparam longint TWO_PI_L  = 64'sd6746518852;
  localparam longint PI_L      = 64'sd3373259426;
  localparam longint HALF_PI_L = 64'sd1686629713;
  localparam longint GAIN_L    = 64'sd652032874;
  localparam longint SQ_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int     SETTLE    = 250;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  dpss_in_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  dpss_out_t out_item;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [31:0] cfg_data = 32'd0;

  always #1 clk = ~clk;

  damped_pendulum_splitting_step_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // The pendulum model of the testbench: registers and state at full width.
  longint regs_m [0:6];
  longint pend_q, pend_p, pend_s, pend_f, pend_e0;
  int     reg_w [0:6] = '{29, 29, 25, 25, 29, 32, 32};
  longint reg_rst [0:6] = '{1677722, 16777216, 16777216, 0, 16777216, 33554432, 0};
  longint atan_l [0:29] = '{
    'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
    'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
    'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
    'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
    'h0000003F, 'h0000001F, 'h0000000F, 'h00000007, 'h00000003, 'h00000001};

  dpss_out_t pending_reports[$];
  int mismatches = 0;
  int failures = 0;
  int items_sent = 0;
  int restarts_sent = 0;
  int reports_seen = 0;

  // The item on the input carries its own typed-in result when cur_lit is set.
  bit        cur_lit = 1'b0;
  dpss_out_t cur_want = '0;

  // Sender burst state and the receiver's long hold-off request.
  int burst_left = 0;
  bit hold_req = 1'b0;

  function automatic longint round_shift(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Sine and cosine: reduce modulo 2*pi, fold to +-pi/2, then CORDIC rotations.
  function automatic void trig_of(input longint ang, output longint sn, output longint cs);
    longint z, x, y, nx;
    bit flip;
    z = (ang * 64) % TWO_PI_L;
    x = GAIN_L;
    y = 0;
    flip = 1'b0;
    if (z >= PI_L) z -= TWO_PI_L;
    else if (z < -PI_L) z += TWO_PI_L;
    if (z > HALF_PI_L) begin
      z -= PI_L;
      flip = 1'b1;
    end else if (z < -HALF_PI_L) begin
      z += PI_L;
      flip = 1'b1;
    end
    for (int t = 0; t < CSTEPS; t++) begin
      if (z >= 0) begin
        nx = x - (y >>> t);
        y = y + (x >>> t);
        z -= atan_l[t];
      end else begin
        nx = x + (y >>> t);
        y = y - (x >>> t);
        z += atan_l[t];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cs = round_shift(x, 30 - FB);
    sn = round_shift(y, 30 - FB);
  endfunction

  function automatic longint force_of(longint q);
    longint sn, cs;
    trig_of(q, sn, cs);
    return clamp32(-round_shift(regs_m[1] * sn, FB));
  endfunction

  function automatic longint energy_of(longint q, longint p, longint s);
    longint sn, cs;
    trig_of(q, sn, cs);
    return round_shift(p * p, FB + 1) - round_shift(regs_m[1] * cs, FB)
         + round_shift(regs_m[4] * s, FB);
  endfunction

  function automatic void load_start_state();
    int v;
    v = int'(regs_m[5]);
    pend_q = longint'(v);
    v = int'(regs_m[6]);
    pend_p = longint'(v);
    pend_s = 0;
    pend_f = force_of(pend_q);
    pend_e0 = clamp32(energy_of(pend_q, pend_p, 0));
  endfunction

  function automatic logic [62:0] square_error(longint a, longint b);
    longint d;
    longint unsigned m, sq;
    d = a - b;
    m = (d < 0) ? -d : d;
    sq = m * m;
    return (sq > SQ_MAX) ? SQ_MAX[62:0] : sq[62:0];
  endfunction

  function automatic void damp_half();
    longint kin;
    kin = clamp32(round_shift(pend_p * pend_p, FB + 1));
    pend_p = clamp32(round_shift(regs_m[2] * pend_p, FB));
    pend_s = clamp32(pend_s + round_shift(regs_m[3] * kin, FB));
  endfunction

  function automatic void kick_half();
    pend_p = clamp32(pend_p + round_shift(regs_m[0] * pend_f, FB + 1));
  endfunction

  // Reports the state for one step item, then advances the pendulum by it.
  function automatic dpss_out_t advance_pendulum(dpss_in_t it);
    dpss_out_t r;
    longint drift;
    int rq, rp, rs;
    if (it.restart) load_start_state();
    drift = clamp32(energy_of(pend_q, pend_p, pend_s) - pend_e0);
    rq = it.ref_position;
    rp = it.ref_momentum;
    rs = it.ref_entropy;
    r.position = pend_q[31:0];
    r.momentum = pend_p[31:0];
    r.entropy = pend_s[31:0];
    r.energy_drift = drift[31:0];
    r.sq_err_position = square_error(pend_q, longint'(rq));
    r.sq_err_momentum = square_error(pend_p, longint'(rp));
    r.sq_err_entropy = square_error(pend_s, longint'(rs));
    r.sq_err_energy = square_error(drift, 0);
    damp_half();
    kick_half();
    pend_q = clamp32(pend_q + round_shift(regs_m[0] * pend_p, FB));
    pend_f = force_of(pend_q);
    kick_half();
    damp_half();
    return r;
  endfunction

  // Monitor: follows reset, register writes and both handshakes at the edge.
  always @(posedge clk) begin
    dpss_out_t want, got;
    if (rst) begin
      for (int i = 0; i < 7; i++) regs_m[i] = reg_rst[i];
      load_start_state();
    end else begin
      if (cfg_write && cfg_index < 3'd7)
        regs_m[cfg_index] = longint'(cfg_data) & ((longint'(1) << reg_w[cfg_index]) - 1);
      if (in_valid && in_ready) begin
        want = advance_pendulum(in_item);
        if (cur_lit) want = cur_want;
        pending_reports.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = out_item;
        reports_seen++;
        if (pending_reports.size() == 0) begin
          failures++;
          $display("unexpected result item at %0t", $realtime);
        end else begin
          want = pending_reports.pop_front();
          if (got.position !== want.position || got.momentum !== want.momentum ||
              got.entropy !== want.entropy || got.energy_drift !== want.energy_drift ||
              got.sq_err_position !== want.sq_err_position ||
              got.sq_err_momentum !== want.sq_err_momentum ||
              got.sq_err_entropy !== want.sq_err_entropy ||
              got.sq_err_energy !== want.sq_err_energy) begin
            mismatches++;
            failures++;
            if (mismatches <= 10) begin
              $display("mismatch on result %0d: q %h/%h p %h/%h s %h/%h drift %h/%h",
                       reports_seen, got.position, want.position, got.momentum,
                       want.momentum, got.entropy, want.entropy, got.energy_drift,
                       want.energy_drift);
              $display("  sq errors got %h %h %h %h want %h %h %h %h",
                       got.sq_err_position, got.sq_err_momentum, got.sq_err_entropy,
                       got.sq_err_energy, want.sq_err_position, want.sq_err_momentum,
                       want.sq_err_entropy, want.sq_err_energy);
            end
          end
        end
      end
    end
  end

  // Receiver: switches among four random stall patterns, and on request holds
  // off for a long stretch so that the core backs up onto its input.
  always @(negedge clk) begin
    static int hold_left = 0;
    static int phase_cnt = 0;
    static int mode = 0;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 600;
      out_ready <= 1'b0;
    end else begin
      if (phase_cnt == 0) mode = $urandom_range(0, 3);
      phase_cnt = (phase_cnt + 1) % 64;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Offers one step item, with a random gap when a burst runs out, and
  // returns once it has been taken.
  task automatic offer_step(input dpss_in_t it, input bit lit, input dpss_out_t want);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item <= it;
    cur_lit = lit;
    cur_want = want;
    items_sent++;
    if (it.restart) restarts_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering items and waits until every result has arrived and the
  // core has finished the step it runs behind the last one.
  task automatic drain_core();
    @(negedge clk);
    in_valid <= 1'b0;
    cur_lit = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Picks a register value: mostly a plausible one, sometimes an extreme or
  // raw random bits (which the core truncates to the register width).
  function automatic logic [31:0] pick_value(int kind, logic [31:0] lo, logic [31:0] hi,
                                             logic [31:0] typ_hi);
    case (kind)
      0: return lo;
      1: return hi;
      2: return $urandom;
      default: return $urandom_range(0, typ_hi);
    endcase
  endfunction

  typedef struct {
    dpss_in_t  item;
    bit        lit;
    dpss_out_t want;
  } step_row_t;

  step_row_t opening_rows [12];

  initial begin
    #4000000;
    $display("damped_pendulum_splitting_step_core test failed");
    $finish;
  end

  initial begin
    dpss_in_t it;
    int kind, nearby, per_phase;
    int iq, ip, is;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Opening table: straight after reset the start state is reported as is;
    // then reference extremes and restarts.
    opening_rows[0] = '{'{1'b0, 32'sd33554432, 32'sd0, 32'sd0}, 1'b1,
                        '{32'sd33554432, 32'sd0, 32'sd0, 32'sd0, 63'd0, 63'd0, 63'd0, 63'd0}};
    opening_rows[1] = '{'{1'b1, 32'sd33554432, 32'h80000000, 32'h7FFFFFFF}, 1'b1,
                        '{32'sd33554432, 32'sd0, 32'sd0, 32'sd0, 63'd0,
                          63'd4611686018427387904, 63'd4611686014132420609, 63'd0}};
    opening_rows[2]  = '{'{1'b0, 32'h0, 32'h0, 32'h0}, 1'b0, '0};
    opening_rows[3]  = '{'{1'b0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF}, 1'b0, '0};
    opening_rows[4]  = '{'{1'b0, 32'h80000000, 32'h80000000, 32'h80000000}, 1'b0, '0};
    opening_rows[5]  = '{'{1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b0, '0};
    opening_rows[6]  = '{'{1'b0, 32'h55555555, 32'hAAAAAAAA, 32'h55555555}, 1'b0, '0};
    opening_rows[7]  = '{'{1'b0, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA}, 1'b0, '0};
    opening_rows[8]  = '{'{1'b1, 32'h7FFFFFFF, 32'h0, 32'h0}, 1'b0, '0};
    opening_rows[9]  = '{'{1'b0, 32'h01000000, 32'hFF000000, 32'h0}, 1'b0, '0};
    opening_rows[10] = '{'{1'b1, 32'h0, 32'h0, 32'h0}, 1'b0, '0};
    opening_rows[11] = '{'{1'b0, 32'h0, 32'h0, 32'h0}, 1'b0, '0};
    foreach (opening_rows[i])
      offer_step(opening_rows[i].item, opening_rows[i].lit, opening_rows[i].want);
    drain_core();

    // Most negative start position against the most positive reference: the
    // squared error does not fit and must saturate.
    write_reg(CFG_START_POSITION, 32'h80000000);
    end_writes();
    offer_step('{1'b1, 32'h7FFFFFFF, 32'h0, 32'h0}, 1'b1,
               '{32'h80000000, 32'sd0, 32'sd0, 32'sd0, SQ_MAX[62:0], 63'd0, 63'd0, 63'd0});
    offer_step('{1'b0, 32'h0, 32'h0, 32'h0}, 1'b0, '0);

    for (int ph = 0; ph < 10; ph++) begin
      drain_core();
      kind = ph < 2 ? ph : $urandom_range(0, 6);
      write_reg(CFG_STEP_SIZE,
                pick_value(kind, 32'd0, ph == 1 ? 32'h1FFFFFFF : 32'd268435456, 32'd4194304));
      kind = ph < 2 ? ph : $urandom_range(0, 6);
      write_reg(CFG_SPRING_CONSTANT, pick_value(kind, 32'd0, 32'd268435456, 32'd67108864));
      kind = ph < 2 ? ph : $urandom_range(0, 6);
      write_reg(CFG_HALF_STEP_DECAY,
                pick_value(kind, 32'd0, ph == 1 ? 32'h01FFFFFF : 32'd16777216, 32'd16777216));
      kind = ph < 2 ? ph : $urandom_range(0, 6);
      write_reg(CFG_HEAT_FRACTION, pick_value(kind, 32'd0, 32'd16777216, 32'd16777216));
      kind = ph < 2 ? ph : $urandom_range(0, 6);
      write_reg(CFG_THERMAL_ENERGY, pick_value(kind, 32'd0, 32'd268435456, 32'd33554432));
      kind = ph < 2 ? ph : $urandom_range(0, 6);
      write_reg(CFG_START_POSITION,
                kind == 3 ? 32'h7FFFFFFF : pick_value(kind, 32'h80000000, 32'h7FFFFFFF,
                                                      32'd134217728) - 32'd67108864);
      kind = ph < 2 ? ph : $urandom_range(0, 6);
      write_reg(CFG_START_MOMENTUM,
                pick_value(kind, 32'h80000000, 32'h7FFFFFFF, 32'd67108864) - 32'd33554432);
      if (ph % 3 == 2) write_reg(CFG_UNUSED, $urandom);
      end_writes();

      per_phase = 168;
      for (int n = 0; n < per_phase; n++) begin
        if (ph == 3 && n == 40) hold_req = 1'b1;
        if (ph == 6 && n == 80) drain_core();
        it.restart = (n == 0) || ($urandom_range(0, 39) == 0);
        nearby = $urandom_range(0, 1);
        iq = int'(pend_q);
        ip = int'(pend_p);
        is = int'(pend_s);
        it.ref_position = nearby ? iq + $urandom_range(0, 2047) - 1024 : $urandom;
        it.ref_momentum = nearby ? ip + $urandom_range(0, 2047) - 1024 : $urandom;
        it.ref_entropy  = nearby ? is + $urandom_range(0, 2047) - 1024 : $urandom;
        offer_step(it, 1'b0, '0);
      end
    end

    drain_core();
    $display("covered %0d step items with %0d restarts over 12 register settings;",
             items_sent, restarts_sent);
    $display("%0d result items checked, %0d mismatching", reports_seen, mismatches);
    if (failures == 0 && pending_reports.size() == 0) begin
      $display("damped_pendulum_splitting_step_core test passed");
    end else begin
      $display("damped_pendulum_splitting_step_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### damped_pendulum_splitting_step_core.f
+incdir+rtl/core
rtl/core/dpss_pkg.sv
rtl/core/dpss_trig.sv
rtl/core/damped_pendulum_splitting_step_core.sv
test/damped_pendulum_splitting_step_core_tb.sv
